[sv/cksk_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package cksk_pkg;

	localparam int DIV_W = 64;
	localparam int DIV_CNT_W = $clog2(DIV_W);
	localparam int XY_W = 34;
	localparam int TRIG_W = 18;

	localparam logic [2:0] CFG_SPEED_MIN = 3'd0;
	localparam logic [2:0] CFG_SPEED_MAX = 3'd1;
	localparam logic [2:0] CFG_ALPHA = 3'd2;
	localparam logic [2:0] CFG_PHASE_GAIN = 3'd3;
	localparam logic [2:0] CFG_STRESS_GAIN = 3'd4;
	localparam logic [2:0] CFG_PISTON_GAIN = 3'd5;
	localparam logic [2:0] CFG_ROD_RATIO = 3'd6;
	localparam logic [2:0] CFG_CRANK_THROW = 3'd7;

	typedef struct packed {
		logic start;
		logic [DIV_W-1:0] dividend;
		logic [DIV_W-1:0] divisor;
	} cksk_div_req_t;

	typedef struct packed {
		logic done;
		logic [DIV_W-1:0] quotient;
	} cksk_div_rsp_t;

	typedef struct packed {
		logic start;
		logic [31:0] phase;
	} cksk_trig_req_t;

	typedef struct packed {
		logic done;
		logic signed [TRIG_W-1:0] cos_v;
		logic signed [TRIG_W-1:0] sin_v;
	} cksk_trig_rsp_t;

	typedef enum logic [5:0] {
		ST_IDLE, ST_LAG, ST_SPD, ST_PHS, ST_SQ, ST_SQL, ST_STL, ST_STH, ST_STS,
		ST_FDS, ST_FDW, ST_CS, ST_CW, ST_C2, ST_C2B, ST_K, ST_K2, ST_BL, ST_BH,
		ST_PL, ST_PH2, ST_PF, ST_SPHI, ST_SQP, ST_SQ0, ST_SQI, ST_RDS, ST_RDW,
		ST_SDM, ST_SDS, ST_SDW, ST_TP1, ST_TP2, ST_TP3, ST_TF, ST_TF2, ST_TQ,
		ST_TQ2, ST_OUT
	} cksk_state_t;

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		logic signed [31:0] r;
		if (v > 66'sd2147483647) begin
			r = 32'sh7FFF_FFFF;
		end else if (v < -66'sd2147483648) begin
			r = 32'sh8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

[sv/cksk_div.sv]
`timescale 1ns / 1ps
`default_nettype none

module cksk_div import cksk_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire cksk_div_req_t req,
	output cksk_div_rsp_t rsp
);

	logic busy_q;
	logic done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_W:0] rem_q;
	logic [DIV_W-1:0] quo_q;
	logic [DIV_W-1:0] dvs_q;
	logic [DIV_W:0] shifted;
	logic fits;

	assign shifted = {rem_q[DIV_W-1:0], quo_q[DIV_W-1]};
	assign fits = shifted >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= fits ? (shifted - {1'b0, dvs_q}) : shifted;
			quo_q <= {quo_q[DIV_W-2:0], fits};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quotient = quo_q;

endmodule

`default_nettype wire

[sv/cksk_cordic.sv]
`timescale 1ns / 1ps
`default_nettype none

module cksk_cordic import cksk_pkg::*; #(
	parameter int STEPS = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire cksk_trig_req_t req,
	output cksk_trig_rsp_t rsp
);

	localparam logic signed [XY_W-1:0] CORDIC_GAIN = 34'sd652032874;

	function automatic logic [31:0] atan_val(input logic [4:0] i);
		logic [31:0] r;
		case (i)
			5'd0: r = 32'h20000000;
			5'd1: r = 32'h12E4051D;
			5'd2: r = 32'h09FB385B;
			5'd3: r = 32'h051111D4;
			5'd4: r = 32'h028B0D43;
			5'd5: r = 32'h0145D7E1;
			5'd6: r = 32'h00A2F61E;
			5'd7: r = 32'h00517C55;
			5'd8: r = 32'h0028BE53;
			5'd9: r = 32'h00145F2F;
			5'd10: r = 32'h000A2F98;
			5'd11: r = 32'h000517CC;
			5'd12: r = 32'h00028BE6;
			5'd13: r = 32'h000145F3;
			5'd14: r = 32'h0000A2FA;
			5'd15: r = 32'h0000517D;
			5'd16: r = 32'h000028BE;
			5'd17: r = 32'h0000145F;
			5'd18: r = 32'h00000A30;
			5'd19: r = 32'h00000518;
			5'd20: r = 32'h0000028C;
			5'd21: r = 32'h00000146;
			5'd22: r = 32'h000000A3;
			5'd23: r = 32'h00000051;
			default: r = 32'h0;
		endcase
		return r;
	endfunction

	function automatic logic signed [TRIG_W-1:0] to_q16(input logic signed [XY_W-1:0] v);
		logic signed [XY_W-1:0] t;
		logic signed [TRIG_W-1:0] r;
		t = (v + 34'sd8192) >>> 14;
		if (t > 34'sd65536) begin
			r = 18'sd65536;
		end else if (t < -34'sd65536) begin
			r = -18'sd65536;
		end else begin
			r = t[TRIG_W-1:0];
		end
		return r;
	endfunction

	logic busy_q;
	logic done_q;
	logic [4:0] i_q;
	logic [1:0] quad_q;
	logic signed [XY_W-1:0] x_q;
	logic signed [XY_W-1:0] y_q;
	logic signed [XY_W-1:0] z_q;
	logic [31:0] ofs;
	logic [1:0] quad;
	logic [31:0] rem;
	logic signed [XY_W-1:0] sh_x;
	logic signed [XY_W-1:0] sh_y;
	logic signed [XY_W-1:0] ang;
	logic signed [TRIG_W-1:0] xc;
	logic signed [TRIG_W-1:0] ys;

	assign ofs = req.phase + 32'h2000_0000;
	assign quad = ofs[31:30];
	assign rem = req.phase - {quad, 30'b0};
	assign sh_x = x_q >>> i_q;
	assign sh_y = y_q >>> i_q;
	assign ang = $signed(XY_W'(atan_val(i_q)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			i_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				i_q <= '0;
			end else if (busy_q) begin
				i_q <= i_q + 1'b1;
				if (i_q == 5'(STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quad_q <= quad;
			x_q <= CORDIC_GAIN;
			y_q <= '0;
			z_q <= XY_W'($signed(rem));
		end else if (busy_q) begin
			if (!z_q[XY_W-1]) begin
				x_q <= x_q - sh_y;
				y_q <= y_q + sh_x;
				z_q <= z_q - ang;
			end else begin
				x_q <= x_q + sh_y;
				y_q <= y_q - sh_x;
				z_q <= z_q + ang;
			end
		end
	end

	assign xc = to_q16(x_q);
	assign ys = to_q16(y_q);

	always_comb begin
		rsp.done = done_q;
		case (quad_q)
			2'd0: begin
				rsp.cos_v = xc;
				rsp.sin_v = ys;
			end
			2'd1: begin
				rsp.cos_v = -ys;
				rsp.sin_v = xc;
			end
			2'd2: begin
				rsp.cos_v = -xc;
				rsp.sin_v = -ys;
			end
			default: begin
				rsp.cos_v = ys;
				rsp.sin_v = -xc;
			end
		endcase
	end

endmodule

`default_nettype wire

[sv/crank_slider_kinematics_step_core.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake          Payload
// in        input      in_valid/in_stall  target_speed
// out       output     out_valid/out_stall speed, crank_angle, stress, stress_factor,
//                                          piston_force, rod_force, tangential_force,
//                                          torque, side_thrust
// cfg       input      cfg_we             cfg_index, cfg_data
//
// One transaction runs up to three passes of the shift-subtract divider, a CORDIC
// rotation of CORDIC_STEPS steps, a bit-pair square root, and its products one after
// another on the shared 33 by 33 bit multiplier.
// The block takes no new input from acceptance until its result has been taken.
// Reset clears the smoothed speed and the angle accumulator and sets the configuration registers to defaults.
// A stalled result holds on the output ports.

module crank_slider_kinematics_step_core import cksk_pkg::*; #(
	parameter int ANGLE_BITS = 24,
	parameter int CORDIC_STEPS = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [2:0] cfg_index,
	input wire logic [31:0] cfg_data,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [21:0] target_speed,
	output logic out_valid,
	input wire logic out_stall,
	output logic [21:0] speed,
	output logic [23:0] crank_angle,
	output logic [31:0] stress,
	output logic [16:0] stress_factor,
	output logic signed [31:0] piston_force,
	output logic signed [31:0] rod_force,
	output logic signed [31:0] tangential_force,
	output logic signed [31:0] torque,
	output logic signed [31:0] side_thrust
);

	cksk_state_t state_q, state_d;

	logic [21:0] speed_min_q, speed_max_q;
	logic [15:0] alpha_q;
	logic [19:0] phase_gain_q;
	logic [31:0] stress_gain_q, piston_gain_q;
	logic [15:0] rod_ratio_q, crank_throw_q;

	logic [21:0] ss_q, tgt_q;
	logic [ANGLE_BITS-1:0] acc_q;
	logic [43:0] sq_q;
	logic [44:0] base_q;
	logic signed [65:0] prod_q, t_q;
	logic [31:0] stress_q;
	logic [16:0] factor_q;
	logic signed [TRIG_W-1:0] c_q, s_q, c2_q, sphi_q;
	logic signed [18:0] k_q, stp_q;
	logic signed [31:0] pf_q, rod_q, side_q, tanf_q, torque_q;
	logic [32:0] rem_q, bit_q;
	logic [33:0] root_q;
	logic neg_q;

	logic signed [32:0] mul_a, mul_b;
	cksk_div_req_t div_req;
	cksk_div_rsp_t div_rsp;
	cksk_trig_req_t trig_req;
	cksk_trig_rsp_t trig_rsp;

	logic [31:0] phase;
	logic signed [23:0] ns;
	logic signed [65:0] sum66, full, pf_div;
	logic [33:0] root_try;
	logic [16:0] cphi;
	logic signed [65:0] quo_s;

	function automatic logic [21:0] clamp_speed(input logic [21:0] v,
		input logic [21:0] lo, input logic [21:0] hi);
		logic [21:0] r;
		r = (v < lo) ? lo : v;
		r = (r > hi) ? hi : r;
		return r;
	endfunction

	assign phase = 32'(acc_q) << (32 - ANGLE_BITS);
	assign cphi = root_q[16:0];
	assign quo_s = neg_q ? -$signed({2'b0, div_rsp.quotient}) : $signed({2'b0, div_rsp.quotient});

	cksk_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.req(div_req),
		.rsp(div_rsp)
	);

	cksk_cordic #(
		.STEPS(CORDIC_STEPS)
	) u_cordic (
		.clk(clk),
		.arst_n(arst_n),
		.req(trig_req),
		.rsp(trig_rsp)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_LAG;
			ST_LAG: state_d = ST_SPD;
			ST_SPD: state_d = ST_PHS;
			ST_PHS: state_d = ST_SQ;
			ST_SQ: state_d = ST_SQL;
			ST_SQL: state_d = ST_STL;
			ST_STL: state_d = ST_STH;
			ST_STH: state_d = ST_STS;
			ST_STS: state_d = ST_FDS;
			ST_FDS: state_d = (speed_max_q == '0) ? ST_CS : ST_FDW;
			ST_FDW: if (div_rsp.done) state_d = ST_CS;
			ST_CS: state_d = ST_CW;
			ST_CW: if (trig_rsp.done) state_d = ST_C2;
			ST_C2: state_d = ST_C2B;
			ST_C2B: state_d = ST_K;
			ST_K: state_d = ST_K2;
			ST_K2: state_d = ST_BL;
			ST_BL: state_d = ST_BH;
			ST_BH: state_d = ST_PL;
			ST_PL: state_d = ST_PH2;
			ST_PH2: state_d = ST_PF;
			ST_PF: state_d = ST_SPHI;
			ST_SPHI: state_d = ST_SQP;
			ST_SQP: state_d = ST_SQ0;
			ST_SQ0: state_d = ST_SQI;
			ST_SQI: if (bit_q == 33'd1) state_d = ST_RDS;
			ST_RDS: state_d = (cphi > 17'd6) ? ST_RDW : ST_TP1;
			ST_RDW: if (div_rsp.done) state_d = ST_SDM;
			ST_SDM: state_d = ST_SDS;
			ST_SDS: state_d = ST_SDW;
			ST_SDW: if (div_rsp.done) state_d = ST_TP1;
			ST_TP1: state_d = ST_TP2;
			ST_TP2: state_d = ST_TP3;
			ST_TP3: state_d = ST_TF;
			ST_TF: state_d = ST_TF2;
			ST_TF2: state_d = ST_TQ;
			ST_TQ: state_d = ST_TQ2;
			ST_TQ2: state_d = ST_OUT;
			ST_OUT: if (!out_stall) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall = (state_q != ST_IDLE);
		out_valid = (state_q == ST_OUT);
		mul_a = '0;
		mul_b = '0;
		div_req.start = 1'b0;
		div_req.dividend = '0;
		div_req.divisor = 64'(cphi);
		trig_req.start = (state_q == ST_CS);
		trig_req.phase = phase;
		case (state_q)
			ST_LAG: begin
				mul_a = 33'($signed({1'b0, tgt_q}) - $signed({1'b0, ss_q}));
				mul_b = $signed(33'(alpha_q));
			end
			ST_PHS: begin
				mul_a = $signed(33'(ss_q));
				mul_b = $signed(33'(phase_gain_q));
			end
			ST_SQ: begin
				mul_a = $signed(33'(ss_q));
				mul_b = $signed(33'(ss_q));
			end
			ST_STL: begin
				mul_a = $signed(33'(sq_q[31:0]));
				mul_b = $signed(33'(stress_gain_q));
			end
			ST_STH: begin
				mul_a = $signed(33'(sq_q[43:32]));
				mul_b = $signed(33'(stress_gain_q));
			end
			ST_STS: begin
				mul_a = $signed(33'(speed_max_q));
				mul_b = $signed(33'(speed_max_q));
			end
			ST_FDS: begin
				div_req.start = (speed_max_q != '0);
				div_req.dividend = 64'({sq_q, 16'b0});
				div_req.divisor = prod_q[63:0];
			end
			ST_C2: begin
				mul_a = 33'(c_q);
				mul_b = 33'(c_q);
			end
			ST_K: begin
				mul_a = $signed(33'(rod_ratio_q));
				mul_b = 33'(c2_q);
			end
			ST_K2: begin
				mul_a = $signed(33'(sq_q[31:0]));
				mul_b = $signed(33'(piston_gain_q));
			end
			ST_BL: begin
				mul_a = $signed(33'(sq_q[43:32]));
				mul_b = $signed(33'(piston_gain_q));
			end
			ST_PL: begin
				mul_a = $signed(33'(base_q[31:0]));
				mul_b = 33'(k_q);
			end
			ST_PH2: begin
				mul_a = $signed(33'(base_q[44:32]));
				mul_b = 33'(k_q);
			end
			ST_PF: begin
				mul_a = $signed(33'(rod_ratio_q));
				mul_b = 33'(s_q);
			end
			ST_SQP: begin
				mul_a = 33'(sphi_q);
				mul_b = 33'(sphi_q);
			end
			ST_RDS: begin
				div_req.start = (cphi > 17'd6);
				div_req.dividend = pf_q[31] ? 64'(-(66'(pf_q) <<< 16)) : 64'(66'(pf_q) <<< 16);
			end
			ST_SDM: begin
				mul_a = 33'(pf_q);
				mul_b = 33'(sphi_q);
			end
			ST_SDS: begin
				div_req.start = 1'b1;
				div_req.dividend = prod_q[65] ? 64'(-prod_q) : prod_q[63:0];
			end
			ST_TP1: begin
				mul_a = 33'(s_q);
				mul_b = $signed(33'(cphi));
			end
			ST_TP2: begin
				mul_a = 33'(c_q);
				mul_b = 33'(sphi_q);
			end
			ST_TF: begin
				mul_a = 33'(rod_q);
				mul_b = 33'(stp_q);
			end
			ST_TQ: begin
				mul_a = 33'(tanf_q);
				mul_b = $signed(33'(crank_throw_q));
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign ns = $signed({2'b0, ss_q}) + prod_q[39:16];
	assign sum66 = prod_q + t_q;
	assign full = (prod_q <<< 32) + t_q;
	assign pf_div = -(full >>> 16);
	assign root_try = root_q + 34'(bit_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ss_q <= '0;
			acc_q <= '0;
			speed_min_q <= 22'd0;
			speed_max_q <= 22'd2048000;
			alpha_q <= 16'd3277;
			phase_gain_q <= 20'd71583;
			stress_gain_q <= 32'd0;
			piston_gain_q <= 32'd0;
			rod_ratio_q <= 16'd16384;
			crank_throw_q <= 16'd3277;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					CFG_SPEED_MIN: speed_min_q <= cfg_data[21:0];
					CFG_SPEED_MAX: speed_max_q <= cfg_data[21:0];
					CFG_ALPHA: alpha_q <= cfg_data[15:0];
					CFG_PHASE_GAIN: phase_gain_q <= cfg_data[19:0];
					CFG_STRESS_GAIN: stress_gain_q <= cfg_data;
					CFG_PISTON_GAIN: piston_gain_q <= cfg_data;
					CFG_ROD_RATIO: rod_ratio_q <= cfg_data[15:0];
					CFG_CRANK_THROW: crank_throw_q <= cfg_data[15:0];
					default: ;
				endcase
			end
			if (state_q == ST_SPD) begin
				ss_q <= clamp_speed(ns[21:0], speed_min_q, speed_max_q);
			end
			if (state_q == ST_SQ) begin
				acc_q <= acc_q + ANGLE_BITS'(prod_q[65:16]);
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		case (state_q)
			ST_IDLE: tgt_q <= clamp_speed(target_speed, speed_min_q, speed_max_q);
			ST_SQL: sq_q <= prod_q[43:0];
			ST_STH: t_q <= prod_q >>> 32;
			ST_STS: stress_q <= (sum66[65:32] != '0) ? 32'hFFFF_FFFF : sum66[31:0];
			ST_FDS: if (speed_max_q == '0) factor_q <= '0;
			ST_FDW: begin
				if (div_rsp.done) begin
					factor_q <= (div_rsp.quotient > 64'd65536) ? 17'd65536
						: div_rsp.quotient[16:0];
				end
			end
			ST_CW: begin
				if (trig_rsp.done) begin
					c_q <= trig_rsp.cos_v;
					s_q <= trig_rsp.sin_v;
				end
			end
			ST_C2B: c2_q <= 18'(20'(prod_q[34:15]) - 20'd65536);
			ST_K2: k_q <= 19'(c_q) + $signed(prod_q[34:16]);
			ST_BL: t_q <= prod_q >>> 32;
			ST_BH: base_q <= 45'(sum66);
			ST_PH2: t_q <= prod_q;
			ST_PF: pf_q <= sat32(pf_div);
			ST_SPHI: sphi_q <= prod_q[33:16];
			ST_SQ0: begin
				rem_q <= 33'h1_0000_0000 - prod_q[32:0];
				root_q <= '0;
				bit_q <= 33'h1_0000_0000;
			end
			ST_SQI: begin
				if (34'(rem_q) >= root_try) begin
					rem_q <= 33'(34'(rem_q) - root_try);
					root_q <= (root_q >> 1) + 34'(bit_q);
				end else begin
					root_q <= root_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			ST_RDS: begin
				neg_q <= pf_q[31];
				if (cphi <= 17'd6) begin
					rod_q <= '0;
					side_q <= '0;
				end
			end
			ST_RDW: if (div_rsp.done) rod_q <= sat32(quo_s);
			ST_SDS: neg_q <= prod_q[65];
			ST_SDW: if (div_rsp.done) side_q <= sat32(quo_s);
			ST_TP2: t_q <= prod_q >>> 16;
			ST_TP3: stp_q <= 19'(t_q + (prod_q >>> 16));
			ST_TF2: tanf_q <= sat32(prod_q >>> 16);
			ST_TQ2: torque_q <= sat32(prod_q >>> 16);
			default: ;
		endcase
	end

	assign speed = ss_q;
	assign crank_angle = phase[31:8];
	assign stress = stress_q;
	assign stress_factor = factor_q;
	assign piston_force = pf_q;
	assign rod_force = rod_q;
	assign tangential_force = tanf_q;
	assign torque = torque_q;
	assign side_thrust = side_q;

endmodule

`default_nettype wire

[sv/cksk_chk.sv]
`timescale 1ns / 1ps
`default_nettype none

module cksk_chk (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_stall,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire logic [21:0] speed,
	input wire logic [16:0] stress_factor
);

	// A stalled result transaction stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// A stalled result transaction keeps its speed.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(speed))
		else $error("result payload changed while stalled");

	// The block takes no input while a result is pending.
	a_busy_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input open while result pending");

	// An accepted input makes the block busy in the next cycle.
	a_busy_after: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall && !out_valid)
		else $error("block not busy after input transaction");

	// The stress factor never exceeds one.
	a_factor: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> stress_factor <= 17'd65536)
		else $error("stress factor above one");

endmodule

bind crank_slider_kinematics_step_core cksk_chk u_cksk_chk (.*);

`default_nettype wire

[sim/crank_slider_kinematics_step_core_tb.sv]
`timescale 1ns / 1ps

module crank_slider_kinematics_step_core_tb import cksk_pkg::*;;

	typedef struct packed {
		logic [21:0] speed;
		logic [23:0] angle;
		logic [31:0] stress;
		logic [16:0] factor;
		logic [31:0] piston;
		logic [31:0] rod;
		logic [31:0] tang;
		logic [31:0] torque;
		logic [31:0] side;
	} kin_result_t;

	class kinematics_board;
		longint unsigned speed_lo, speed_hi, alpha, phase_gain, stress_gain, piston_gain;
		longint unsigned lambda, throw_q16, kept_speed, angle_acc;
		kin_result_t pending[$];
		int mismatches, checked, strays;

		function new();
			speed_lo = 0; speed_hi = 2048000; alpha = 3277; phase_gain = 71583;
			stress_gain = 0; piston_gain = 0; lambda = 16384; throw_q16 = 3277;
			kept_speed = 0; angle_acc = 0;
		endfunction

		function void set_reg(logic [2:0] idx, logic [31:0] val);
			case (idx)
				CFG_SPEED_MIN: speed_lo = val[21:0];
				CFG_SPEED_MAX: speed_hi = val[21:0];
				CFG_ALPHA: alpha = val[15:0];
				CFG_PHASE_GAIN: phase_gain = val[19:0];
				CFG_STRESS_GAIN: stress_gain = val;
				CFG_PISTON_GAIN: piston_gain = val;
				CFG_ROD_RATIO: lambda = val[15:0];
				CFG_CRANK_THROW: throw_q16 = val[15:0];
				default: ;
			endcase
		endfunction

		function longint unsigned limit_speed(longint unsigned v);
			if (v < speed_lo) v = speed_lo;
			if (v > speed_hi) v = speed_hi;
			return v;
		endfunction

		function longint sat_word(longint v);
			if (v > 64'sd2147483647) return 64'sd2147483647;
			if (v < -64'sd2147483648) return -64'sd2147483648;
			return v;
		endfunction

		function longint unsigned mul_hi32(longint unsigned a, longint unsigned b);
			return (a >> 32) * b + (((a & 64'hFFFF_FFFF) * b) >> 32);
		endfunction

		function longint unsigned int_sqrt(longint unsigned v);
			longint unsigned r, bitv;
			r = 0;
			bitv = 64'd1 << 62;
			while (bitv > v) bitv >>= 2;
			while (bitv != 0) begin
				if (v >= r + bitv) begin
					v -= r + bitv;
					r = (r >> 1) + bitv;
				end else begin
					r >>= 1;
				end
				bitv >>= 2;
			end
			return r;
		endfunction

		function longint round_q16(longint v);
			v = (v + 8192) >>> 14;
			if (v > 65536) v = 65536;
			if (v < -65536) v = -65536;
			return v;
		endfunction

		function void rotate(longint unsigned phase, output longint c, output longint s);
			longint unsigned atan_q[24] = '{
				32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
				32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
				32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
				32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
				32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051};
			longint unsigned quad, d;
			longint z, x, y, nx, xc, ys;
			quad = ((phase + 64'h2000_0000) >> 30) & 3;
			d = (phase - (quad << 30)) & 64'hFFFF_FFFF;
			z = (d >= 64'h8000_0000) ? longint'(d) - 64'sd4294967296 : longint'(d);
			x = 652032874;
			y = 0;
			for (int i = 0; i < 16; i++) begin
				if (z >= 0) begin
					nx = x - (y >>> i); y = y + (x >>> i); z -= longint'(atan_q[i]);
				end else begin
					nx = x + (y >>> i); y = y - (x >>> i); z += longint'(atan_q[i]);
				end
				x = nx;
			end
			xc = round_q16(x);
			ys = round_q16(y);
			case (quad)
				0: begin c = xc; s = ys; end
				1: begin c = -ys; s = xc; end
				2: begin c = -xc; s = -ys; end
				default: begin c = ys; s = -xc; end
			endcase
		endfunction

		function void note_input(logic [21:0] target_in);
			longint unsigned tgt, sq, phase, strs, fac, cphi;
			longint diff, ns, c, s, c2, k, base, pf, sphi, rod, stp, tf, tq, side, lam;
			kin_result_t e;
			lam = longint'(lambda);
			tgt = limit_speed(target_in);
			diff = longint'(tgt) - longint'(kept_speed);
			ns = longint'(kept_speed) + ((diff * longint'(alpha)) >>> 16);
			kept_speed = limit_speed(longint'(ns));
			angle_acc = (angle_acc + ((kept_speed * phase_gain) >> 16)) & 64'hFF_FFFF;
			phase = (angle_acc << 8) & 64'hFFFF_FFFF;
			sq = kept_speed * kept_speed;
			strs = mul_hi32(sq, stress_gain);
			if (strs > 64'hFFFF_FFFF) strs = 64'hFFFF_FFFF;
			fac = 0;
			if (speed_hi != 0) begin
				fac = (sq << 16) / (speed_hi * speed_hi);
				if (fac > 65536) fac = 65536;
			end
			rotate(phase, c, s);
			c2 = ((2 * c * c) >>> 16) - 65536;
			k = c + ((lam * c2) >>> 16);
			base = longint'(mul_hi32(sq, piston_gain));
			pf = sat_word(-((base * k) >>> 16));
			sphi = (lam * s) >>> 16;
			cphi = int_sqrt((64'd1 << 32) - longint'(sphi * sphi));
			if (cphi > 6) begin
				rod = sat_word((pf * 65536) / longint'(cphi));
				side = sat_word((pf * sphi) / longint'(cphi));
			end else begin
				rod = 0;
				side = 0;
			end
			stp = ((s * longint'(cphi)) >>> 16) + ((c * sphi) >>> 16);
			tf = sat_word((rod * stp) >>> 16);
			tq = sat_word((tf * longint'(throw_q16)) >>> 16);
			e.speed = kept_speed[21:0];
			e.angle = angle_acc[23:0];
			e.stress = strs[31:0];
			e.factor = fac[16:0];
			e.piston = pf[31:0];
			e.rod = rod[31:0];
			e.tang = tf[31:0];
			e.torque = tq[31:0];
			e.side = side[31:0];
			pending.push_back(e);
		endfunction

		function void check_result(kin_result_t a);
			kin_result_t e;
			if (pending.size() == 0) begin
				strays++;
				if (strays + mismatches <= 10) $display("unexpected result transaction");
				return;
			end
			e = pending.pop_front();
			checked++;
			if (a != e) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("mismatch %0d: exp spd=%0d ang=%0d str=%0d fac=%0d pf=%0d",
						mismatches, e.speed, e.angle, e.stress, e.factor, $signed(e.piston));
					$display("    exp rod=%0d tf=%0d tq=%0d sd=%0d",
						$signed(e.rod), $signed(e.tang), $signed(e.torque), $signed(e.side));
					$display("    got spd=%0d ang=%0d str=%0d fac=%0d pf=%0d",
						a.speed, a.angle, a.stress, a.factor, $signed(a.piston));
					$display("    got rod=%0d tf=%0d tq=%0d sd=%0d",
						$signed(a.rod), $signed(a.tang), $signed(a.torque), $signed(a.side));
				end
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [2:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic in_valid = 0;
	logic in_stall;
	logic [21:0] target_speed = '0;
	logic out_valid;
	logic out_stall = 0;
	logic [21:0] speed;
	logic [23:0] crank_angle;
	logic [31:0] stress;
	logic [16:0] stress_factor;
	logic signed [31:0] piston_force, rod_force, tangential_force, torque, side_thrust;

	kinematics_board board = new();
	int send_idle_pct, recv_stall_pct;
	bit hold_output = 0;
	int quiet_cycles = 0;
	int items_sent = 0;

	crank_slider_kinematics_step_core DUT (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	always @(posedge clk) begin
		kin_result_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.speed = speed; got.angle = crank_angle; got.stress = stress;
			got.factor = stress_factor; got.piston = piston_force; got.rod = rod_force;
			got.tang = tangential_force; got.torque = torque; got.side = side_thrust;
			board.check_result(got);
		end
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || !arst_n) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= 6000) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	initial begin
		forever begin
			@(negedge clk);
			if (hold_output) begin
				out_stall <= 1;
				repeat (900) @(negedge clk);
				hold_output = 0;
			end else begin
				out_stall <= ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		@(negedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		board.set_reg(idx, val);
		@(negedge clk);
		cfg_we <= 0;
	endtask

	task automatic wait_drained();
		while (board.pending.size() != 0) @(negedge clk);
		repeat (10) @(negedge clk);
	endtask

	task automatic send_speed(logic [21:0] tgt);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			@(negedge clk);
		end
		in_valid <= 1;
		target_speed <= tgt;
		do @(posedge clk); while (in_stall);
		board.note_input(tgt);
		items_sent++;
		@(negedge clk);
		in_valid <= 0;
	endtask

	task automatic random_setup(bit extreme);
		logic [21:0] hi;
		hi = extreme ? 22'h3FFFFF : 22'($urandom_range(1, 4194303));
		write_reg(CFG_SPEED_MIN, extreme ? 0 : $urandom_range(0, hi / 4));
		write_reg(CFG_SPEED_MAX, 32'(hi));
		write_reg(CFG_ALPHA, extreme ? 65535 : $urandom_range(0, 65535));
		write_reg(CFG_PHASE_GAIN, $urandom_range(0, 1048575));
		write_reg(CFG_STRESS_GAIN, $urandom);
		write_reg(CFG_PISTON_GAIN, extreme ? 32'hFFFF_FFFF : $urandom);
		write_reg(CFG_ROD_RATIO, extreme ? 65535 : $urandom_range(0, 65535));
		write_reg(CFG_CRANK_THROW, extreme ? 65535 : $urandom_range(0, 65535));
	endtask

	initial begin
		send_idle_pct = 0;
		recv_stall_pct = 0;
		repeat (8) @(negedge clk);
		arst_n = 1;

		send_speed(22'd0);
		send_speed(22'h3FFFFF);
		send_speed(22'd2048000);
		wait_drained();
		write_reg(CFG_SPEED_MIN, 1000);
		write_reg(CFG_SPEED_MAX, 32'h3FFFFF);
		write_reg(CFG_ALPHA, 65535);
		write_reg(CFG_PHASE_GAIN, 32'hFFFFF);
		write_reg(CFG_STRESS_GAIN, 32'hFFFF_FFFF);
		write_reg(CFG_PISTON_GAIN, 32'hFFFF_FFFF);
		write_reg(CFG_ROD_RATIO, 65535);
		write_reg(CFG_CRANK_THROW, 65535);
		for (int i = 0; i < 8; i++) send_speed(i[0] ? 22'h3FFFFF : 22'h155555 << i[1]);
		wait_drained();
		write_reg(CFG_SPEED_MIN, 3000000);
		write_reg(CFG_SPEED_MAX, 20000);
		write_reg(CFG_ALPHA, 0);
		send_speed(22'd0);
		send_speed(22'h3FFFFF);
		wait_drained();
		write_reg(CFG_ALPHA, 40000);
		send_speed(22'd100);
		send_speed(22'd1250000);
		wait_drained();
		write_reg(CFG_SPEED_MIN, 0);
		write_reg(CFG_SPEED_MAX, 0);
		send_speed(22'd12345);
		wait_drained();
		write_reg(CFG_SPEED_MAX, 1);
		write_reg(CFG_ALPHA, 65535);
		write_reg(CFG_ROD_RATIO, 0);
		write_reg(CFG_CRANK_THROW, 0);
		write_reg(CFG_PISTON_GAIN, 0);
		write_reg(CFG_STRESS_GAIN, 0);
		write_reg(CFG_PHASE_GAIN, 0);
		send_speed(22'd1);
		send_speed(22'h2AAAAA);

		for (int p = 0; p < 9; p++) begin
			wait_drained();
			random_setup(p % 4 == 3);
			case (p / 3)
				0: begin send_idle_pct = 27; recv_stall_pct = 54; end
				1: begin send_idle_pct = 54; recv_stall_pct = 27; end
				default: begin send_idle_pct = 0; recv_stall_pct = 0; end
			endcase
			if (p == 6) hold_output = 1;
			for (int i = 0; i < 198; i++) begin
				case ($urandom_range(3))
					0: send_speed(22'($urandom_range(0, 4194303)));
					1: send_speed(22'($urandom_range(0, board.speed_hi)));
					2: send_speed(22'($urandom_range(board.speed_lo, board.speed_lo + 2000)));
					default: send_speed(22'($urandom_range(board.speed_hi / 2, board.speed_hi)));
				endcase
			end
		end

		wait_drained();
		repeat (300) @(negedge clk);
		$display("%0d speed transactions sent, %0d results checked over 9 random setups",
			items_sent, board.checked);
		$display("with directed limits, crossed limits, zero full scale and a long output hold.");
		if (board.mismatches == 0 && board.strays == 0 && board.pending.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
